@@ rtl/ptbl_pkg.sv @@
// Shared types and constants for the two-level page table engine.
// No dependencies; imported by every other file of the block but ptbl_if.
`default_nettype none

package ptbl_pkg;

  // Pool of on-chip page tables and their geometry
  localparam int NUM_TABLES = 16;
  localparam int IDX_W      = 10;
  localparam int ENTRIES    = 1 << IDX_W;
  localparam int TBL_W      = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
  localparam int CNT_W      = $clog2(NUM_TABLES + 1);
  localparam int TBL_AW     = TBL_W + IDX_W;
  localparam int TBL_DEPTH  = NUM_TABLES * ENTRIES;

  // Page table entry flag bits
  localparam logic [11:0] PTE_PRESENT  = 12'h001;
  localparam logic [11:0] PTE_WRITABLE = 12'h002;

  typedef enum logic [1:0] {
    OP_MAP   = 2'd0,
    OP_UNMAP = 2'd1,
    OP_XLATE = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NO_TABLE  = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_DECIDE,
    S_CLEAR,
    S_WRITE,
    S_CHECK
  } state_e;

  typedef struct packed {
    logic             present;
    logic [TBL_W-1:0] tbl;
  } dir_ent_t;

  // Controller to datapath
  typedef struct packed {
    logic    capture;
    logic    init_wr;
    logic    clear_wr;
    logic    claim;
    logic    tbl_wr;
    logic    use_cur;
    logic    tbl_rd;
    logic    load_res;
    status_e res_status;
    logic    res_flush;
    logic    res_phys;
  } ptbl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    op_e  op;
    logic dir_present;
    logic pool_full;
    logic ent_present;
    logic sweep_last;
    logic out_free;
  } ptbl_sts_t;

endpackage

`default_nettype wire

@@ rtl/ptbl_if.sv @@
// Request and response channel interfaces of the page table engine.
// Plain valid/ready handshake; no package dependency.
`default_nettype none

interface ptbl_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] virt_addr;
  logic [31:0] phys_addr;
  logic [11:0] page_flags;

  modport source (output valid, op, virt_addr, phys_addr, page_flags, input ready);
  modport sink   (input valid, op, virt_addr, phys_addr, page_flags, output ready);
endinterface

interface ptbl_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] phys_out;
  logic        tlb_flush;

  modport source (output valid, status, phys_out, tlb_flush, input ready);
  modport sink   (input valid, status, phys_out, tlb_flush, output ready);
endinterface

`default_nettype wire

@@ rtl/two_level_page_table_engine_top.sv @@
// Two-level page table engine, top level; one item in flight at a time.
// A translate through a present directory entry answers after dependent directory
// and table reads; a map that claims a table first clears it in a sweep over its
// entries; every other item answers after the directory read. The next item is
// taken once the response is loaded; a stalled response holds off its completion.
// After reset a sweep points directory entry 0 at table 0 and identity-fills it.
`default_nettype none

module two_level_page_table_engine_top
  import ptbl_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ptbl_req_if.sink   req_i,
  ptbl_rsp_if.source rsp_o
);

  ptbl_cmd_t cmd;
  ptbl_sts_t sts;
  logic      req_ready;

  // Sequencer
  ptbl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Memories and response register
  ptbl_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .req_op_i         (req_i.op),
    .req_virt_addr_i  (req_i.virt_addr),
    .req_phys_addr_i  (req_i.phys_addr),
    .req_page_flags_i (req_i.page_flags),
    .rsp_valid_o      (rsp_o.valid),
    .rsp_ready_i      (rsp_o.ready),
    .rsp_status_o     (rsp_o.status),
    .rsp_phys_out_o   (rsp_o.phys_out),
    .rsp_tlb_flush_o  (rsp_o.tlb_flush)
  );

  assign req_i.ready = req_ready;

endmodule

`default_nettype wire

@@ rtl/ptbl_dp.sv @@
// Datapath: directory and table memories, pool counter, sweep counter and
// the response register. Depends on ptbl_pkg; driven by ptbl_ctrl.
`default_nettype none

module ptbl_dp
  import ptbl_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire ptbl_cmd_t   cmd_i,
  output      ptbl_sts_t   sts_o,
  input  wire logic [1:0]  req_op_i,
  input  wire logic [31:0] req_virt_addr_i,
  input  wire logic [31:0] req_phys_addr_i,
  input  wire logic [11:0] req_page_flags_i,
  output      logic        rsp_valid_o,
  input  wire logic        rsp_ready_i,
  output      logic [1:0]  rsp_status_o,
  output      logic [31:0] rsp_phys_out_o,
  output      logic        rsp_tlb_flush_o
);

  // Captured request
  op_e         op_q;
  logic [31:0] va_q;
  logic [31:0] pa_q;
  logic [11:0] flags_q;

  dir_ent_t    dir_mem [ENTRIES];
  logic [31:0] tbl_mem [TBL_DEPTH];
  dir_ent_t    dir_rd_q;
  logic [31:0] tbl_rd_q;

  logic [CNT_W-1:0] tables_used_q;
  logic [TBL_W-1:0] cur_tbl_q;
  logic [IDX_W-1:0] cnt_q;

  logic        out_valid_q;
  status_e     out_status_q;
  logic [31:0] out_phys_q;
  logic        out_flush_q;

  logic [IDX_W-1:0]  dir_idx;
  logic [IDX_W-1:0]  tbl_idx;
  logic [TBL_W-1:0]  new_tbl;
  logic [TBL_W-1:0]  tbl_sel;
  logic              pool_full;
  logic              out_free;
  logic              tbl_we;
  logic [TBL_AW-1:0] tbl_waddr;
  logic [31:0]       tbl_wdata;

  assign dir_idx   = va_q[31:22];
  assign tbl_idx   = va_q[21:12];
  assign new_tbl   = tables_used_q[TBL_W-1:0];
  assign tbl_sel   = cmd_i.use_cur ? cur_tbl_q : dir_rd_q.tbl;
  assign pool_full = (tables_used_q == CNT_W'(NUM_TABLES));
  assign out_free  = !out_valid_q || rsp_ready_i;

  // Capture the request payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= op_e'(req_op_i);
      va_q    <= req_virt_addr_i;
      pa_q    <= req_phys_addr_i;
      flags_q <= req_page_flags_i;
    end
  end

  // Pool and sweep counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tables_used_q <= CNT_W'(1);
      cnt_q         <= '0;
    end else begin
      if (cmd_i.claim) begin
        tables_used_q <= tables_used_q + CNT_W'(1);
      end
      if (cmd_i.init_wr || cmd_i.clear_wr) begin
        cnt_q <= cnt_q + IDX_W'(1);
      end
    end
  end

  // Remember the table just claimed for the clear sweep and entry write
  always_ff @(posedge clk_i) begin
    if (cmd_i.claim) begin
      cur_tbl_q <= new_tbl;
    end
  end

  // Directory memory: write during init or claim, read on capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.init_wr) begin
      dir_mem[cnt_q] <= (cnt_q == '0) ? dir_ent_t'{present: 1'b1, tbl: '0} : '0;
    end else if (cmd_i.claim) begin
      dir_mem[dir_idx] <= dir_ent_t'{present: 1'b1, tbl: new_tbl};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      dir_rd_q <= dir_mem[req_virt_addr_i[31:22]];
    end
  end

  // Table write port: identity fill, table clear or single entry
  always_comb begin
    tbl_we    = cmd_i.init_wr || cmd_i.clear_wr || cmd_i.tbl_wr;
    tbl_waddr = {tbl_sel, tbl_idx};
    tbl_wdata = (op_q == OP_MAP) ? {pa_q[31:12], flags_q | PTE_PRESENT} : '0;
    if (cmd_i.init_wr) begin
      tbl_waddr = {TBL_W'(0), cnt_q};
      tbl_wdata = {(20 - IDX_W)'(0), cnt_q, PTE_PRESENT | PTE_WRITABLE};
    end else if (cmd_i.clear_wr) begin
      tbl_waddr = {cur_tbl_q, cnt_q};
      tbl_wdata = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_mem[tbl_waddr] <= tbl_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.tbl_rd) begin
      tbl_rd_q <= tbl_mem[{dir_rd_q.tbl, tbl_idx}];
    end
  end

  // Response register: load on completion, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_res) begin
      out_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_res) begin
      out_status_q <= cmd_i.res_status;
      out_flush_q  <= cmd_i.res_flush;
      out_phys_q   <= cmd_i.res_phys ? {tbl_rd_q[31:12], va_q[11:0]} : '0;
    end
  end

  assign rsp_valid_o     = out_valid_q;
  assign rsp_status_o    = out_status_q;
  assign rsp_phys_out_o  = out_phys_q;
  assign rsp_tlb_flush_o = out_flush_q;

  // Status back to the controller
  assign sts_o.op          = op_q;
  assign sts_o.dir_present = dir_rd_q.present;
  assign sts_o.pool_full   = pool_full;
  assign sts_o.ent_present = tbl_rd_q[0];
  assign sts_o.sweep_last  = (cnt_q == {IDX_W{1'b1}});
  assign sts_o.out_free    = out_free;

  a_pool_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tables_used_q != '0) && (tables_used_q <= CNT_W'(NUM_TABLES)))
    else $error("table pool count out of range");

  a_claim_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.claim |-> !pool_full)
    else $error("table claimed from an exhausted pool");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_res |-> out_free)
    else $error("response loaded over an untaken item");

  a_flush_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_flush_q |-> (out_status_q == ST_DONE) && (out_phys_q == '0))
    else $error("flush raised on a failed or translate response");

endmodule

`default_nettype wire

@@ rtl/ptbl_ctrl.sv @@
// Controller state machine: init sweep, request sequencing, table claim.
// Depends on ptbl_pkg; commands ptbl_dp.
`default_nettype none

module ptbl_ctrl
  import ptbl_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      req_valid_i,
  output      logic      req_ready_o,
  input  wire ptbl_sts_t sts_i,
  output      ptbl_cmd_t cmd_o
);

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d          = state_q;
    req_ready_o      = 1'b0;
    cmd_o            = '0;
    cmd_o.res_status = ST_DONE;
    case (state_q)
      S_INIT: begin
        cmd_o.init_wr = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        req_ready_o   = 1'b1;
        cmd_o.capture = req_valid_i;
        if (req_valid_i) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts_i.out_free) begin
          state_d = S_IDLE;
          case (sts_i.op)
            OP_MAP: begin
              if (sts_i.dir_present) begin
                cmd_o.tbl_wr    = 1'b1;
                cmd_o.load_res  = 1'b1;
                cmd_o.res_flush = 1'b1;
              end else if (sts_i.pool_full) begin
                cmd_o.load_res   = 1'b1;
                cmd_o.res_status = ST_NO_TABLE;
              end else begin
                cmd_o.claim = 1'b1;
                state_d     = S_CLEAR;
              end
            end
            OP_UNMAP: begin
              cmd_o.load_res = 1'b1;
              if (sts_i.dir_present) begin
                cmd_o.tbl_wr    = 1'b1;
                cmd_o.res_flush = 1'b1;
              end else begin
                cmd_o.res_status = ST_NOT_FOUND;
              end
            end
            OP_XLATE: begin
              if (sts_i.dir_present) begin
                cmd_o.tbl_rd = 1'b1;
                state_d      = S_CHECK;
              end else begin
                cmd_o.load_res   = 1'b1;
                cmd_o.res_status = ST_NOT_FOUND;
              end
            end
            default: begin
              cmd_o.load_res = 1'b1;
            end
          endcase
        end
      end
      S_CLEAR: begin
        cmd_o.clear_wr = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = S_WRITE;
        end
      end
      S_WRITE: begin
        if (sts_i.out_free) begin
          cmd_o.tbl_wr    = 1'b1;
          cmd_o.use_cur   = 1'b1;
          cmd_o.load_res  = 1'b1;
          cmd_o.res_flush = 1'b1;
          state_d         = S_IDLE;
        end
      end
      S_CHECK: begin
        if (sts_i.out_free) begin
          cmd_o.load_res   = 1'b1;
          cmd_o.res_phys   = sts_i.ent_present;
          cmd_o.res_status = sts_i.ent_present ? ST_DONE : ST_NOT_FOUND;
          state_d          = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  a_clear_to_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) && sts_i.sweep_last |=> (state_q == S_WRITE))
    else $error("table clear did not end in the entry write");

  a_capture_decide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> (state_q == S_DECIDE))
    else $error("captured item not decoded next cycle");

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_ready_o |-> (state_q == S_IDLE))
    else $error("request taken outside idle");

endmodule

`default_nettype wire
